[src/assert_macros.svh]
// Assertion helpers for the execute unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/rv32x_pkg.sv]
// ----------------------------------------------------------------------------
// rv32x_pkg
// Shared constants and types of the RV32IM execute unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rv32x_pkg;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned RegCountDef = 32;

  localparam logic [6:0] OpReg    = 7'b0110011;
  localparam logic [6:0] OpLoad   = 7'b0000011;
  localparam logic [6:0] OpStore  = 7'b0100011;
  localparam logic [6:0] OpImm    = 7'b0010011;
  localparam logic [6:0] OpFence  = 7'b0001111;
  localparam logic [6:0] OpSystem = 7'b1110011;
  localparam logic [6:0] OpBranch = 7'b1100011;
  localparam logic [6:0] OpLui    = 7'b0110111;
  localparam logic [6:0] OpAuipc  = 7'b0010111;
  localparam logic [6:0] OpJal    = 7'b1101111;
  localparam logic [6:0] OpJalr   = 7'b1100111;

  localparam logic [1:0] ReqNone  = 2'd0;
  localparam logic [1:0] ReqRead  = 2'd1;
  localparam logic [1:0] ReqWrite = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StIllegal = 2'd1;
  localparam logic [1:0] StFence   = 2'd2;

  // Divider operation select
  typedef struct packed {
    logic start;
    logic signed_op;
    logic want_rem;
  } div_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage
`default_nettype wire

[src/rv32x_div.sv]
// ----------------------------------------------------------------------------
// rv32x_div
// Radix-2 restoring divider, one quotient bit per cycle, spec corner cases.
// ----------------------------------------------------------------------------
`default_nettype none
module rv32x_div
  import rv32x_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire div_cmd_t              cmd,
  input  wire logic [DATA_WIDTH-1:0] dividend,
  input  wire logic [DATA_WIDTH-1:0] divisor,
  output div_stat_t                  stat,
  output logic      [DATA_WIDTH-1:0] result
);
  localparam int unsigned CW = $clog2(DATA_WIDTH + 1);

  logic [DATA_WIDTH-1:0] quo, dsr, orig;
  logic [DATA_WIDTH:0]   rem;
  logic [CW-1:0]         count;
  logic                  busy, done, neg_q, neg_r, want_rem, by_zero;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH-1:0] abs_a, abs_b, q_fix, r_fix;

  assign abs_a = (cmd.signed_op && dividend[DATA_WIDTH-1]) ? -dividend : dividend;
  assign abs_b = (cmd.signed_op && divisor[DATA_WIDTH-1]) ? -divisor : divisor;
  assign shifted = {rem[DATA_WIDTH-1:0], quo[DATA_WIDTH-1]};
  assign trial = shifted - {1'b0, dsr};
  assign q_fix = neg_q ? -quo : quo;
  assign r_fix = neg_r ? -rem[DATA_WIDTH-1:0] : rem[DATA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        count <= CW'(DATA_WIDTH);
        quo <= abs_a;
        dsr <= abs_b;
        orig <= dividend;
        rem <= '0;
        want_rem <= cmd.want_rem;
        by_zero <= (divisor == '0);
        neg_q <= cmd.signed_op && (dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1]);
        neg_r <= cmd.signed_op && dividend[DATA_WIDTH-1];
      end else if (busy) begin
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
          if (by_zero) result <= want_rem ? orig : '1;
          else result <= want_rem ? r_fix : q_fix;
        end else begin
          count <= count - 1'b1;
          if (!trial[DATA_WIDTH]) begin
            rem <= trial;
            quo <= {quo[DATA_WIDTH-2:0], 1'b1};
          end else begin
            rem <= shifted;
            quo <= {quo[DATA_WIDTH-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
endmodule
`default_nettype wire

[src/rv32x_regfile.sv]
// ----------------------------------------------------------------------------
// rv32x_regfile
// Register file: one write port, one registered read port, cleared by sweep.
// ----------------------------------------------------------------------------
`default_nettype none
module rv32x_regfile
  import rv32x_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned REG_COUNT  = RegCountDef
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [$clog2(REG_COUNT)-1:0] waddr,
  input  wire logic [DATA_WIDTH-1:0]        wdata,
  input  wire logic [$clog2(REG_COUNT)-1:0] raddr,
  output logic      [DATA_WIDTH-1:0]        rdata
);
  logic [DATA_WIDTH-1:0] mem [REG_COUNT];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/rv32im_execute_unit_core.sv]
// ----------------------------------------------------------------------------
// rv32im_execute_unit_core
// Multi-cycle RV32IM execute unit with a shared ALU, iterative divider and
// a register file memory.
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  s_axis   | in  | tuser: kind; tdata: instruction[31:0], load_data[63:32]
//  m_axis   | out | tdata: mem_request, mem_address, access_size, store_data,
//           |     |        next_pc, status, dest_write, dest_index, dest_value
//  cfg      | in  | start_address
// After reset the register file is cleared, one entry per cycle; input opens
// once the last clear write has landed. An instruction steps through two
// register-file reads, execute, writeback and output; a multiply adds a
// product state, a divide waits in the divider until done. A load response
// goes straight to writeback and output. The output register holds a result
// until taken; a new item is accepted only when the sequencer is idle.
// ----------------------------------------------------------------------------
`default_nettype none
module rv32im_execute_unit_core
  import rv32x_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned REG_COUNT  = RegCountDef
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [31:0]   cfg_wdata,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [63:0]   s_axis_tdata,   // instruction, load_data
  input  wire logic          s_axis_tuser,   // kind
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // mem_request[1:0], mem_address[33:2], access_size[35:34], store_data[67:36],
  // next_pc[99:68], status[101:100], dest_write[102], dest_index[107:103],
  // dest_value[139:108], zero pad
  output logic [143:0]       m_axis_tdata
);
  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(REG_COUNT);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RDA   = 9'b000000100,
    S_RDB   = 9'b000001000,
    S_EXEC  = 9'b000010000,
    S_MULH  = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_WB    = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state;
  logic [AW-1:0] clr_idx;
  logic [31:0] pc, inst, ldata, a, b;
  logic kind;
  logic load_pending, load_unsigned;
  logic [AW-1:0] load_dest;
  logic [1:0] load_size;

  logic [1:0] o_req, o_size, o_status;
  logic [31:0] o_addr, o_sdata, o_npc, o_val;
  logic o_we;
  logic [4:0] o_idx;
  logic [63:0] prod;

  // register file
  logic rf_we;
  logic [AW-1:0] rf_waddr, rf_raddr;
  logic [DATA_WIDTH-1:0] rf_wdata, rf_rdata;

  rv32x_regfile #(.DATA_WIDTH(DATA_WIDTH), .REG_COUNT(REG_COUNT)) u_rf (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rf_raddr), .rdata(rf_rdata)
  );

  div_cmd_t dcmd;
  div_stat_t dstat;
  logic [31:0] dres;
  rv32x_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
    .clk(clk), .rst(rst), .cmd(dcmd), .dividend(a), .divisor(b),
    .stat(dstat), .result(dres)
  );

  // decode
  logic [6:0] op, f7;
  logic [2:0] f3;
  logic [4:0] rd;
  logic [31:0] immi, imms, immb, immj, immu;
  assign op = inst[6:0];
  assign rd = inst[11:7];
  assign f3 = inst[14:12];
  assign f7 = inst[31:25];
  assign immi = {{20{inst[31]}}, inst[31:20]};
  assign imms = {{20{inst[31]}}, inst[31:25], inst[11:7]};
  assign immb = {{19{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
  assign immj = {{11{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};
  assign immu = {inst[31:12], 12'd0};

  logic is_mul, is_div;
  assign is_mul = (op == OpReg) && (f7 == 7'h01) && !f3[2];
  assign is_div = (op == OpReg) && (f7 == 7'h01) && f3[2];

  // shared ALU: operand select and one result
  logic [31:0] opb, alu, addsum;
  logic lts, ltu;
  logic [4:0] sh;
  always_comb begin
    opb = (op == OpReg || op == OpBranch) ? b : immi;
    sh = opb[4:0];
    addsum = a + ((op == OpReg && f7 == 7'h20) ? (~opb + 32'd1) : opb);
    lts = $signed(a) < $signed(opb);
    ltu = a < opb;
    case (f3)
      3'd0: alu = addsum;
      3'd1: alu = a << sh;
      3'd2: alu = {31'd0, lts};
      3'd3: alu = {31'd0, ltu};
      3'd4: alu = a ^ opb;
      3'd5: alu = f7[5] ? 32'($signed(a) >>> sh) : a >> sh;
      3'd6: alu = a | opb;
      default: alu = a & opb;
    endcase
  end

  // execute decode into result fields
  logic [1:0] x_req, x_size, x_status;
  logic [31:0] x_addr, x_sdata, x_npc, x_val;
  logic x_we, x_ld, take;
  always_comb begin
    x_req = ReqNone; x_size = 2'd0; x_status = StOk; x_addr = '0; x_sdata = '0;
    x_npc = pc + 32'd4; x_val = '0; x_we = 1'b0; x_ld = 1'b0; take = 1'b0;
    unique case (op)
      OpReg: begin
        if (f7 == 7'h00 || (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5))) begin
          x_we = 1'b1; x_val = alu;
        end else if (f7 != 7'h01) x_status = StIllegal;
        else x_we = 1'b1;
      end
      OpLoad: begin
        if (f3 == 3'd3 || f3 >= 3'd6) x_status = StIllegal;
        else begin
          x_req = ReqRead; x_addr = a + immi; x_size = f3[1:0]; x_ld = 1'b1;
        end
      end
      OpStore: begin
        if (f3 > 3'd2) x_status = StIllegal;
        else begin
          x_req = ReqWrite; x_addr = a + imms; x_size = f3[1:0];
          x_sdata = (f3 == 3'd0) ? {24'd0, b[7:0]} :
                    (f3 == 3'd1) ? {16'd0, b[15:0]} : b;
        end
      end
      OpImm: begin
        if (f3 == 3'd1 && f7 != 7'h00) x_status = StIllegal;
        else if (f3 == 3'd5 && f7 != 7'h00 && f7 != 7'h20) x_status = StIllegal;
        else begin
          x_we = 1'b1; x_val = alu;
        end
      end
      OpFence: x_status = StFence;
      OpSystem: begin
        if (f3 == 3'd4) x_status = StIllegal;
        else if (f3 == 3'd0 && inst[31:20] > 12'd1) x_status = StIllegal;
      end
      OpBranch: begin
        case (f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd4: take = lts;
          3'd5: take = !lts;
          3'd6: take = ltu;
          3'd7: take = !ltu;
          default: x_status = StIllegal;
        endcase
        if (take) x_npc = pc + immb;
      end
      OpLui: begin
        x_we = 1'b1; x_val = immu;
      end
      OpAuipc: begin
        x_we = 1'b1; x_val = pc + immu;
      end
      OpJal: begin
        x_we = 1'b1; x_val = pc + 32'd4; x_npc = pc + immj;
      end
      OpJalr: begin
        if (f3 != 3'd0) x_status = StIllegal;
        else begin
          x_we = 1'b1; x_val = pc + 32'd4; x_npc = (a + immi) & ~32'd1;
        end
      end
      default: x_status = StIllegal;
    endcase
  end

  // load response formatting
  logic [31:0] ld_val;
  always_comb begin
    case (load_size)
      2'd0: ld_val = load_unsigned ? {24'd0, ldata[7:0]} : {{24{ldata[7]}}, ldata[7:0]};
      2'd1: ld_val = load_unsigned ? {16'd0, ldata[15:0]}
                                   : {{16{ldata[15]}}, ldata[15:0]};
      default: ld_val = ldata;
    endcase
  end

  // multiply operands, 33-bit signed
  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod;
  assign ma = {(f3 == 3'd1 || f3 == 3'd2) && a[31], a};
  assign mb = {(f3 == 3'd1) && b[31], b};
  assign mprod = ma * mb;

  assign rf_raddr = (state == S_IDLE) ? s_axis_tdata[19:15] : inst[24:20];
  // hold off while a register write is still landing
  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid && !rf_we;

  always_comb begin
    dcmd.start = (state == S_EXEC) && is_div;
    dcmd.signed_op = !f3[0];
    dcmd.want_rem = f3[1];
  end

  logic write_x0;
  assign write_x0 = (o_idx == 5'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      pc <= '0;
      load_pending <= 1'b0;
      load_dest <= '0;
      load_size <= '0;
      load_unsigned <= 1'b0;
      m_axis_tvalid <= 1'b0;
      rf_we <= 1'b0;
    end else begin
      rf_we <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cfg_we) pc <= cfg_wdata;
      unique case (state)
        S_CLEAR: begin
          rf_we <= 1'b1; rf_waddr <= clr_idx; rf_wdata <= '0;
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(REG_COUNT - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            kind <= s_axis_tuser;
            inst <= s_axis_tdata[31:0];
            ldata <= s_axis_tdata[63:32];
            state <= s_axis_tuser ? S_WB : S_RDA;
          end
        end
        S_RDA: begin
          a <= (inst[19:15] == 5'd0) ? '0 : rf_rdata;
          state <= S_RDB;
        end
        S_RDB: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (is_div) state <= S_DIV;
          else if (is_mul) state <= S_MULH;
          else state <= S_WB;
        end
        S_MULH: begin
          prod <= mprod[63:0];
          state <= S_WB;
        end
        S_DIV: begin
          if (dstat.done) state <= S_WB;
        end
        S_WB: begin
          o_req <= ReqNone; o_addr <= '0; o_size <= '0; o_sdata <= '0;
          o_status <= StOk; o_we <= 1'b0; o_idx <= '0; o_val <= '0;
          if (kind) begin
            o_npc <= pc;
            if (load_pending) begin
              o_we <= 1'b1; o_idx <= load_dest; o_val <= ld_val;
            end
            load_pending <= 1'b0;
          end else begin
            o_req <= x_req; o_addr <= x_addr; o_size <= x_size; o_sdata <= x_sdata;
            o_status <= x_status; o_npc <= x_npc; pc <= x_npc;
            o_we <= x_we; o_idx <= rd;
            o_val <= is_div ? dres : !is_mul ? x_val :
                     (f3 == 3'd0) ? prod[31:0] : prod[63:32];
            load_pending <= x_ld;
            if (x_ld) begin
              load_dest <= rd; load_size <= f3[1:0]; load_unsigned <= f3[2];
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          rf_we <= o_we && !write_x0; rf_waddr <= o_idx; rf_wdata <= o_val;
          m_axis_tvalid <= 1'b1;
          m_axis_tdata <= {4'd0, (o_we && !write_x0) ? o_val : 32'd0,
                           (o_we && !write_x0) ? o_idx : 5'd0, o_we && !write_x0,
                           o_status, o_npc, o_sdata, o_size, o_addr, o_req};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_RDB) b <= (inst[24:20] == 5'd0) ? '0 : rf_rdata;
    end
  end

  `ASSERT_IMPL(a_ready_idle, clk, rst, s_axis_tready, state == S_IDLE, "ready outside idle")
  `ASSERT_NEXT(a_div_wait, clk, rst, dcmd.start, dstat.busy, "divider did not start")
  `ASSERT_IMPL(a_no_x0, clk, rst, rf_we && state != S_CLEAR && state != S_IDLE, rf_waddr != 5'd0,
               "write to x0")
endmodule
`default_nettype wire

[dv/rv32im_execute_unit_core_tb.sv]
// ----------------------------------------------------------------------------
// rv32im_execute_unit_core_tb
// Self-checking bench for the RV32IM execute unit: a directed table followed
// by random instruction streams. Each result is predicted from the bench's own
// register file and pc or hand-typed, and compared field by field, in order.
// ----------------------------------------------------------------------------
module rv32im_execute_unit_core_tb;
  import rv32x_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] dest_value;
    logic [4:0]  dest_index;
    logic        dest_write;
    logic [1:0]  status;
    logic [31:0] next_pc;
    logic [31:0] store_data;
    logic [1:0]  access_size;
    logic [31:0] mem_address;
    logic [1:0]  mem_request;
  } exec_result_t;

  typedef struct {
    bit           kind;
    logic [31:0]  word;
    logic [31:0]  ld;
    bit           typed;
    exec_result_t res;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [31:0]  cfg_wdata = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata = '0;   // instruction, load_data
  logic         s_axis_tuser = 1'b0; // kind
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;        // see exec_result_t, lowest field last

  // Side channel traveling with each offered item: a hand-typed expectation
  bit           drv_typed = 1'b0;
  exec_result_t drv_res = '0;

  logic [31:0]  gpr [32];
  logic [31:0]  pc_model;
  bit           ld_pending;
  logic [4:0]   ld_rd;
  logic [1:0]   ld_size;
  bit           ld_unsigned;

  exec_result_t expected_q[$];
  stim_row_t    rows[$];
  int           idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both
  int           hold_cycles = 0;
  bit           failed = 1'b0;

  rv32im_execute_unit_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

  function automatic logic [31:0] sx(logic [31:0] v, int bits);
    logic [31:0] m;
    m = 32'd1 << (bits - 1);
    v = v & ((m << 1) - 1);
    return (v ^ m) - m;
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OpStore};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OpBranch};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OpJal};
  endfunction

  function automatic void wr_gpr(ref exec_result_t r, input logic [4:0] rd,
                                 input logic [31:0] v);
    if (rd != 5'd0) begin
      gpr[rd] = v;
      r.dest_write = 1'b1;
      r.dest_index = rd;
      r.dest_value = v;
    end
  endfunction

  // Advance the architectural state by one item and return its result
  function automatic exec_result_t execute_item(bit kind, logic [31:0] w, logic [31:0] ld);
    exec_result_t r;
    logic [6:0]   op, f7;
    logic [4:0]   rd;
    logic [2:0]   f3;
    logic [31:0]  a, b, imm, npc, v, off;
    longint       sa, sb, prod;
    logic [63:0]  uprod;
    bit           take;
    r = '0;
    if (kind) begin
      if (ld_pending) begin
        v = ld & (ld_size == 2'd0 ? 32'hFF : (ld_size == 2'd1 ? 32'hFFFF : 32'hFFFFFFFF));
        if (!ld_unsigned && ld_size < 2'd2) v = sx(v, ld_size == 2'd0 ? 8 : 16);
        wr_gpr(r, ld_rd, v);
        ld_pending = 1'b0;
      end
      r.next_pc = pc_model;
      return r;
    end
    ld_pending = 1'b0;
    op = w[6:0];
    rd = w[11:7];
    f3 = w[14:12];
    f7 = w[31:25];
    a = gpr[w[19:15]];
    b = gpr[w[24:20]];
    imm = sx(w[31:20], 12);
    npc = pc_model + 32'd4;
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    case (op)
      OpReg: begin
        if (f7 == 7'h00) begin
          case (f3)
            3'd0: v = a + b;
            3'd1: v = a << b[4:0];
            3'd2: v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            3'd3: v = (a < b) ? 32'd1 : 32'd0;
            3'd4: v = a ^ b;
            3'd5: v = a >> b[4:0];
            3'd6: v = a | b;
            default: v = a & b;
          endcase
          wr_gpr(r, rd, v);
        end else if (f7 == 7'h20 && (f3 == 3'd0 || f3 == 3'd5)) begin
          v = (f3 == 3'd0) ? a - b : 32'($signed(a) >>> b[4:0]);
          wr_gpr(r, rd, v);
        end else if (f7 == 7'h01) begin
          case (f3)
            3'd0: v = a * b;
            3'd1: begin prod = sa * sb; v = prod[63:32]; end
            3'd2: begin prod = sa * longint'({32'd0, b}); v = prod[63:32]; end
            3'd3: begin uprod = {32'd0, a} * {32'd0, b}; v = uprod[63:32]; end
            3'd4: v = (b == 0) ? 32'hFFFFFFFF : 32'(sa / sb);
            3'd5: v = (b == 0) ? 32'hFFFFFFFF : a / b;
            3'd6: v = (b == 0) ? a : 32'(sa % sb);
            default: v = (b == 0) ? a : a % b;
          endcase
          wr_gpr(r, rd, v);
        end else begin
          r.status = StIllegal;
        end
      end
      OpLoad: begin
        if (f3 == 3'd3 || f3 >= 3'd6) begin
          r.status = StIllegal;
        end else begin
          ld_pending = 1'b1;
          ld_rd = rd;
          ld_size = f3[1:0];
          ld_unsigned = f3[2];
          r.mem_request = ReqRead;
          r.mem_address = a + imm;
          r.access_size = f3[1:0];
        end
      end
      OpStore: begin
        if (f3 > 3'd2) begin
          r.status = StIllegal;
        end else begin
          r.mem_request = ReqWrite;
          r.mem_address = a + sx({w[31:25], w[11:7]}, 12);
          r.access_size = f3[1:0];
          r.store_data = b & (f3 == 3'd0 ? 32'hFF : (f3 == 3'd1 ? 32'hFFFF : 32'hFFFFFFFF));
        end
      end
      OpImm: begin
        case (f3)
          3'd0: wr_gpr(r, rd, a + imm);
          3'd2: wr_gpr(r, rd, ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0);
          3'd3: wr_gpr(r, rd, (a < imm) ? 32'd1 : 32'd0);
          3'd4: wr_gpr(r, rd, a ^ imm);
          3'd6: wr_gpr(r, rd, a | imm);
          3'd7: wr_gpr(r, rd, a & imm);
          3'd1: begin
            if (f7 == 7'h00) wr_gpr(r, rd, a << w[24:20]);
            else r.status = StIllegal;
          end
          default: begin
            if (f7 == 7'h00) wr_gpr(r, rd, a >> w[24:20]);
            else if (f7 == 7'h20) wr_gpr(r, rd, 32'($signed(a) >>> w[24:20]));
            else r.status = StIllegal;
          end
        endcase
      end
      OpFence: r.status = StFence;
      OpSystem: begin
        if (f3 == 3'd4 || (f3 == 3'd0 && w[31:20] > 12'd1)) r.status = StIllegal;
      end
      OpBranch: begin
        off = sx({w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
        case (f3)
          3'd0: take = (a == b);
          3'd1: take = (a != b);
          3'd4: take = ($signed(a) < $signed(b));
          3'd5: take = !($signed(a) < $signed(b));
          3'd6: take = (a < b);
          3'd7: take = (a >= b);
          default: begin
            take = 1'b0;
            r.status = StIllegal;
          end
        endcase
        if (take) npc = pc_model + off;
      end
      OpLui: wr_gpr(r, rd, {w[31:12], 12'd0});
      OpAuipc: wr_gpr(r, rd, pc_model + {w[31:12], 12'd0});
      OpJal: begin
        off = sx({w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
        wr_gpr(r, rd, pc_model + 32'd4);
        npc = pc_model + off;
      end
      OpJalr: begin
        if (f3 != 3'd0) begin
          r.status = StIllegal;
        end else begin
          npc = (a + imm) & ~32'd1;
          wr_gpr(r, rd, pc_model + 32'd4);
        end
      end
      default: r.status = StIllegal;
    endcase
    pc_model = npc;
    r.next_pc = npc;
    return r;
  endfunction

  // Predict on every accepted input item
  always @(posedge clk) begin
    exec_result_t r;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      r = execute_item(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32]);
      expected_q.push_back(drv_typed ? drv_res : r);
    end
  end

  function automatic void cmp_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, e, a);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    exec_result_t e, a;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      a = exec_result_t'(m_axis_tdata);
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_axis_tdata);
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        cmp_field("mem_request", e.mem_request, a.mem_request);
        cmp_field("mem_address", e.mem_address, a.mem_address);
        cmp_field("access_size", e.access_size, a.access_size);
        cmp_field("store_data", e.store_data, a.store_data);
        cmp_field("next_pc", e.next_pc, a.next_pc);
        cmp_field("status", e.status, a.status);
        cmp_field("dest_write", e.dest_write, a.dest_write);
        cmp_field("dest_index", e.dest_index, a.dest_index);
        cmp_field("dest_value", e.dest_value, a.dest_value);
      end
    end
  end

  // Result side: always ready, random stalls in modes 2 and 3, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else if (idle_mode == 2) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 72);
    end else if (idle_mode == 3) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 23);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_item(bit kind, logic [31:0] w, logic [31:0] ld, bit typed,
                           exec_result_t res);
    int pct;
    pct = (idle_mode == 1) ? 72 : ((idle_mode == 3) ? 23 : 0);
    while ($urandom_range(0, 99) < pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {ld, w};
    drv_typed <= typed;
    drv_res <= res;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic drain_and_configure(logic [31:0] addr);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we <= 1'b0;
    pc_model = addr;
  endtask

  function automatic logic [4:0] rreg();
    return ($urandom_range(0, 19) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [31:0] random_word();
    logic [6:0] f7s [4];
    int         sel;
    f7s = '{7'h00, 7'h01, 7'h20, 7'($urandom)};
    sel = $urandom_range(0, 99);
    if (sel < 22) return enc_r(f7s[$urandom_range(0, 3)], rreg(), rreg(), 3'($urandom), rreg(),
                               OpReg);
    if (sel < 40) return enc_i(12'($urandom), rreg(), 3'($urandom), rreg(), OpImm);
    if (sel < 44) return enc_i({($urandom_range(0, 3) == 0) ? 7'h20 : 7'h00, 5'($urandom)},
                               rreg(), ($urandom_range(0, 1) != 0) ? 3'd1 : 3'd5, rreg(), OpImm);
    if (sel < 52) return {20'($urandom), rreg(), ($urandom_range(0, 1) != 0) ? OpLui : OpAuipc};
    if (sel < 62) return enc_i(12'($urandom), rreg(), 3'($urandom), rreg(), OpLoad);
    if (sel < 68) return enc_s(12'($urandom), rreg(), rreg(), 3'($urandom_range(0, 3)));
    if (sel < 76) return enc_b(13'($urandom), rreg(), rreg(), 3'($urandom));
    if (sel < 80) return enc_j(21'($urandom), rreg());
    if (sel < 84) return enc_i(12'($urandom), rreg(), ($urandom_range(0, 4) == 0) ? 3'd1 : 3'd0,
                               rreg(), OpJalr);
    if (sel < 87) return enc_i(12'($urandom_range(0, 2)), 5'd0, 3'($urandom), 5'd0, OpSystem);
    if (sel < 89) return {25'($urandom), OpFence};
    return $urandom;
  endfunction

  task automatic add_row(bit kind, logic [31:0] w, logic [31:0] ld);
    stim_row_t row;
    row.kind = kind;
    row.word = w;
    row.ld = ld;
    row.typed = 1'b0;
    row.res = '0;
    rows.push_back(row);
  endtask

  initial begin
    logic [31:0]   addrs [5];
    logic [31:0]   w;
    exec_result_t  none;
    none = '0;
    addrs = '{32'h0000_0100, 32'h0, 32'hFFFF_FFFC, 32'hFFFF_FFFF, $urandom};
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    pc_model = '0;
    ld_pending = 1'b0;
    ld_rd = '0;
    ld_size = '0;
    ld_unsigned = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    repeat (40) @(posedge clk);

    // Directed table, run from start address 0x100
    add_row(0, 32'h0000_0000, '0);                              // unknown opcode
    rows[$].typed = 1; rows[$].res = '0;
    rows[$].res.status = StIllegal; rows[$].res.next_pc = 32'h104;
    add_row(0, {25'd0, OpFence}, '0);
    rows[$].typed = 1; rows[$].res = '0;
    rows[$].res.status = StFence; rows[$].res.next_pc = 32'h108;
    add_row(1, '0, 32'hDEAD_BEEF);                              // stray load response
    rows[$].typed = 1; rows[$].res = '0; rows[$].res.next_pc = 32'h108;
    add_row(0, {20'h80000, 5'd1, OpLui}, '0);
    add_row(0, enc_i(12'hFFF, 5'd0, 3'd0, 5'd2, OpImm), '0);
    rows[$].typed = 1; rows[$].res = '0; rows[$].res.next_pc = 32'h110;
    rows[$].res.dest_write = 1; rows[$].res.dest_index = 5'd2;
    rows[$].res.dest_value = 32'hFFFF_FFFF;
    add_row(0, enc_i(12'h7FF, 5'd0, 3'd0, 5'd3, OpImm), '0);
    add_row(0, enc_r(7'h00, 5'd2, 5'd1, 3'd0, 5'd4, OpReg), '0);
    add_row(0, enc_r(7'h20, 5'd3, 5'd1, 3'd0, 5'd5, OpReg), '0);
    add_row(0, enc_r(7'h00, 5'd3, 5'd2, 3'd1, 5'd6, OpReg), '0);
    add_row(0, enc_r(7'h20, 5'd3, 5'd1, 3'd5, 5'd6, OpReg), '0);
    add_row(0, enc_r(7'h00, 5'd3, 5'd1, 3'd3, 5'd7, OpReg), '0);
    add_row(0, enc_r(7'h01, 5'd1, 5'd1, 3'd1, 5'd4, OpReg), '0);
    add_row(0, enc_r(7'h01, 5'd2, 5'd1, 3'd2, 5'd4, OpReg), '0);
    add_row(0, enc_r(7'h01, 5'd2, 5'd2, 3'd3, 5'd4, OpReg), '0);
    add_row(0, enc_r(7'h01, 5'd2, 5'd1, 3'd4, 5'd4, OpReg), '0); // signed overflow
    add_row(0, enc_r(7'h01, 5'd2, 5'd1, 3'd6, 5'd5, OpReg), '0);
    add_row(0, enc_r(7'h01, 5'd0, 5'd2, 3'd5, 5'd4, OpReg), '0); // divide by zero
    add_row(0, enc_r(7'h01, 5'd0, 5'd2, 3'd7, 5'd5, OpReg), '0);
    add_row(0, enc_i(12'd5, 5'd0, 3'd0, 5'd0, OpImm), '0);      // x0 stays zero
    add_row(0, enc_i(12'd0, 5'd3, 3'd0, 5'd6, OpLoad), '0);
    add_row(1, '0, 32'h1234_5680);
    add_row(0, enc_s(12'hFFF, 5'd2, 5'd1, 3'd2), '0);
    add_row(0, enc_b(13'h1FFC, 5'd0, 5'd0, 3'd0), '0);
    add_row(0, enc_j(21'h100000, 5'd1), '0);
    add_row(0, enc_i(12'd1, 5'd2, 3'd0, 5'd7, OpJalr), '0);
    add_row(0, {20'hFFFFF, 5'd8, OpAuipc}, '0);
    add_row(0, enc_i(12'd2, 5'd0, 3'd0, 5'd0, OpSystem), '0);   // bad system imm
    add_row(0, enc_i(12'h401, 5'd1, 3'd1, 5'd9, OpImm), '0);    // slli with bad funct7

    drain_and_configure(addrs[0]);
    foreach (rows[i]) send_item(rows[i].kind, rows[i].word, rows[i].ld, rows[i].typed,
                                rows[i].res);

    for (int ph = 0; ph < 5; ph++) begin
      drain_and_configure(addrs[(ph + 1) % 5]);
      idle_mode = ph % 4;
      if (ph == 4) hold_cycles = 400;  // starve the output, keep offering input
      for (int n = 0; n < 125; n++) begin
        if ($urandom_range(0, 24) == 0) begin
          send_item(1, $urandom, $urandom, 0, none);
        end else begin
          w = random_word();
          send_item(0, w, $urandom, 0, none);
          if (w[6:0] == OpLoad && $urandom_range(0, 9) < 8)
            send_item(1, $urandom, $urandom, 0, none);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    idle_mode = 0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (!failed && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+src
src/rv32x_pkg.sv
src/rv32x_div.sv
src/rv32x_regfile.sv
src/rv32im_execute_unit_core.sv
dv/rv32im_execute_unit_core_tb.sv
